// ===== hw/rtl/dmr_pkg.sv =====
// Shared types, constants and helper functions for the dual motor ramp unit.
// Used by dmr_lane, dmr_ctrl, dmr_speed and the top level; depends on nothing.
package dmr_pkg;

	localparam int CMD_W = 11;
	localparam int MIN_W = 10;
	localparam int SPD_W = 8;
	localparam int WRK_W = 12;

	typedef logic signed [CMD_W-1:0] level_t;
	typedef logic signed [WRK_W-1:0] wrk_t;
	typedef logic signed [SPD_W-1:0] speed_t;
	typedef logic [MIN_W-1:0]        mag10_t;

	localparam wrk_t NEAR_ZERO = 12'sd10;
	localparam wrk_t CUT_MAG   = 12'sd100;
	localparam wrk_t TURN_DIFF = 12'sd50;
	localparam wrk_t SMALL_MAG = 12'sd2;

	localparam logic [2:0] STOP_TICKS = 3'd5;
	localparam logic [2:0] STOP_MAX   = 3'd7;

	localparam logic [15:0] SPEED_RECIP = 16'd33555;
	localparam int          SPEED_SHIFT = 18;
	localparam logic [8:0]  SPEED_MAX   = 9'd127;

	localparam logic [1:0] REG_LEVEL_LIMIT = 2'd0;
	localparam logic [1:0] REG_MIN_STRAIGHT = 2'd1;
	localparam logic [1:0] REG_MIN_TURNING = 2'd2;

	localparam mag10_t RST_LEVEL_LIMIT = 10'd600;
	localparam mag10_t RST_MIN_STRAIGHT = 10'd80;
	localparam mag10_t RST_MIN_TURNING = 10'd100;

	typedef enum logic [1:0] {
		TGT_HOLD,
		TGT_LOAD,
		TGT_CLEAR
	} tgt_mode_t;

	typedef struct packed {
		tgt_mode_t mode;
		mag10_t    old_min;
	} tgt_ctrl_t;

	typedef struct packed {
		mag10_t new_min;
		logic   cut;
		mag10_t limit;
	} lvl_ctrl_t;

	function automatic wrk_t mag(input wrk_t v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic wrk_t ext(input level_t v);
		return wrk_t'(v);
	endfunction

	function automatic wrk_t umin(input mag10_t m);
		return wrk_t'({2'b00, m});
	endfunction

endpackage

// ===== hw/rtl/dmr_lane.sv =====
// One drive channel: target update, ramp step with clamp, and deadband handling.
// Uses dmr_pkg; driven by the shared control from dmr_ctrl.
module dmr_lane (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  dmr_pkg::level_t    command,
	input  dmr_pkg::tgt_ctrl_t tgc,
	input  dmr_pkg::lvl_ctrl_t lvc,
	output dmr_pkg::wrk_t      target_mid,
	output dmr_pkg::wrk_t      ramped,
	output dmr_pkg::level_t    level_next,
	output dmr_pkg::level_t    emit
);

	dmr_pkg::level_t level_q;
	dmr_pkg::level_t target_q;
	dmr_pkg::level_t target_next;

	function automatic dmr_pkg::wrk_t push_min(input dmr_pkg::wrk_t v, input dmr_pkg::wrk_t m);
		if (v > 0 && v < m) return m;
		if (v < 0 && v > -m) return -m;
		return v;
	endfunction

	function automatic dmr_pkg::wrk_t push_above2(input dmr_pkg::wrk_t v,
	                                              input dmr_pkg::wrk_t m);
		if (v > dmr_pkg::SMALL_MAG && v < m) return m;
		if (v < -dmr_pkg::SMALL_MAG && v > -m) return -m;
		return v;
	endfunction

	function automatic dmr_pkg::wrk_t cut_small(input dmr_pkg::wrk_t v);
		return (v < dmr_pkg::CUT_MAG && v > -dmr_pkg::CUT_MAG) ? '0 : v;
	endfunction

	function automatic dmr_pkg::wrk_t ramp(input dmr_pkg::wrk_t l, input dmr_pkg::wrk_t t,
	                                       input dmr_pkg::wrk_t lim);
		dmr_pkg::wrk_t inc;
		dmr_pkg::wrk_t n;
		inc = (l < dmr_pkg::NEAR_ZERO && l > -dmr_pkg::NEAR_ZERO) ? 12'sd1 : 12'sd2;
		n = l;
		if (l < t) begin
			n = l + inc;
			if (n > t) n = t;
		end else if (l > t) begin
			n = l - inc;
			if (n < t) n = t;
		end
		if (n > lim) n = lim;
		if (n < -lim) n = -lim;
		return n;
	endfunction

	dmr_pkg::wrk_t old_min_w;
	dmr_pkg::wrk_t new_min_w;
	dmr_pkg::wrk_t pushed_lvl;

	always_comb begin
		old_min_w = dmr_pkg::umin(tgc.old_min);
		new_min_w = dmr_pkg::umin(lvc.new_min);
		case (tgc.mode)
			dmr_pkg::TGT_LOAD:  target_mid = push_min(dmr_pkg::ext(command), old_min_w);
			dmr_pkg::TGT_CLEAR: target_mid = '0;
			default:            target_mid = dmr_pkg::ext(target_q);
		endcase
		ramped = ramp(dmr_pkg::ext(level_q), target_mid, dmr_pkg::umin(lvc.limit));
		pushed_lvl = push_above2(ramped, new_min_w);
		if (lvc.cut) begin
			level_next  = ramped[dmr_pkg::CMD_W-1:0];
			emit        = dmr_pkg::level_t'(cut_small(ramped));
			target_next = dmr_pkg::level_t'(cut_small(target_mid));
		end else begin
			level_next  = pushed_lvl[dmr_pkg::CMD_W-1:0];
			emit        = pushed_lvl[dmr_pkg::CMD_W-1:0];
			target_next = dmr_pkg::level_t'(push_above2(target_mid, new_min_w));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= '0;
			target_q <= '0;
		end else if (accept) begin
			level_q  <= level_next;
			target_q <= target_next;
		end
	end

endmodule

// ===== hw/rtl/dmr_ctrl.sv =====
// Shared control for both lanes: stop counter, running flag, active minimum
// and the cut decision taken from the left lane. Uses dmr_pkg.
module dmr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               stop_released,
	input  dmr_pkg::level_t    left_command,
	input  dmr_pkg::level_t    right_command,
	input  dmr_pkg::mag10_t    level_limit,
	input  dmr_pkg::mag10_t    min_level_straight,
	input  dmr_pkg::mag10_t    min_level_turning,
	input  dmr_pkg::wrk_t      left_target_mid,
	input  dmr_pkg::wrk_t      right_target_mid,
	input  dmr_pkg::wrk_t      left_ramped,
	input  dmr_pkg::level_t    left_level_next,
	output dmr_pkg::tgt_ctrl_t tgc,
	output dmr_pkg::lvl_ctrl_t lvc,
	output logic               running_next
);

	logic [2:0]      stop_cnt_q;
	logic [2:0]      cnt_inc;
	logic            running_q;
	dmr_pkg::mag10_t act_min_q;
	dmr_pkg::level_t prev_left_q;
	logic            opposite;
	dmr_pkg::wrk_t   diff;

	always_comb begin
		cnt_inc = (stop_cnt_q == dmr_pkg::STOP_MAX) ? dmr_pkg::STOP_MAX : stop_cnt_q + 3'd1;
		tgc.old_min = act_min_q;
		if (stop_released) begin
			tgc.mode     = dmr_pkg::TGT_LOAD;
			running_next = 1'b1;
		end else if (cnt_inc >= dmr_pkg::STOP_TICKS) begin
			tgc.mode     = dmr_pkg::TGT_CLEAR;
			running_next = 1'b0;
		end else begin
			tgc.mode     = dmr_pkg::TGT_HOLD;
			running_next = running_q;
		end
		opposite = (left_target_mid > 0 && right_target_mid < 0) ||
		           (left_target_mid < 0 && right_target_mid > 0);
		diff = dmr_pkg::mag(dmr_pkg::mag(dmr_pkg::ext(left_command)) -
		                    dmr_pkg::mag(dmr_pkg::ext(right_command)));
		lvc.new_min = (opposite && diff < dmr_pkg::TURN_DIFF) ? min_level_turning
		                                                      : min_level_straight;
		lvc.cut   = dmr_pkg::mag(dmr_pkg::ext(prev_left_q)) >= dmr_pkg::mag(left_ramped);
		lvc.limit = level_limit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_cnt_q  <= '0;
			running_q   <= 1'b0;
			act_min_q   <= '0;
			prev_left_q <= '0;
		end else if (accept) begin
			stop_cnt_q  <= stop_released ? 3'd0 : cnt_inc;
			running_q   <= running_next;
			act_min_q   <= lvc.new_min;
			prev_left_q <= left_level_next;
		end
	end

endmodule

// ===== hw/rtl/dmr_speed.sv =====
// Registered conversion of a drive level to a motor speed, level*128/1000
// truncated toward zero and saturated. Uses dmr_pkg.
module dmr_speed (
	input  logic            clk,
	input  logic            en,
	input  dmr_pkg::level_t level,
	output dmr_pkg::speed_t speed
);

	logic [dmr_pkg::CMD_W-1:0]    lvl_mag;
	logic [dmr_pkg::CMD_W+15:0]   prod;
	logic [8:0]                   quo;
	logic [8:0]                   sat;
	dmr_pkg::speed_t              speed_s2;

	always_comb begin
		lvl_mag = level[dmr_pkg::CMD_W-1] ? dmr_pkg::CMD_W'(-level) : dmr_pkg::CMD_W'(level);
		prod    = (dmr_pkg::CMD_W+16)'(lvl_mag) * (dmr_pkg::CMD_W+16)'(dmr_pkg::SPEED_RECIP);
		quo     = prod[dmr_pkg::SPEED_SHIFT+8:dmr_pkg::SPEED_SHIFT];
		sat     = (quo > dmr_pkg::SPEED_MAX) ? dmr_pkg::SPEED_MAX : quo;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			speed_s2 <= level[dmr_pkg::CMD_W-1] ? -dmr_pkg::speed_t'(sat[7:0])
			                                    : dmr_pkg::speed_t'(sat[7:0]);
		end
	end

	assign speed = speed_s2;

endmodule

// ===== hw/rtl/dual_motor_ramp_with_deadband_unit.sv =====
// Dual motor ramp with deadband: two ramp lanes with shared stop and deadband control.
// An accepted transaction updates the ramp state and is held in stage 1, then in the
// output register; one transaction per cycle unless the output stalls.
// Reset clears all ramp state, the stop counter and the pipeline valids, and
// returns the configuration registers to 600, 80 and 100.
// Depends on dmr_pkg, dmr_lane, dmr_ctrl and dmr_speed.
module dual_motor_ramp_with_deadband_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // left_command [10:0], right_command [21:11], zeros above
	input  logic        s_tuser,   // stop_released
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // left_speed [7:0], right_speed [15:8],
	                               // left_level_out [26:16], right_level_out [37:27], zeros above
	output logic        m_tuser,   // running
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	dmr_pkg::mag10_t    level_limit_q;
	dmr_pkg::mag10_t    min_straight_q;
	dmr_pkg::mag10_t    min_turning_q;
	logic               accept;
	logic               adv2;
	logic               valid_s1;
	logic               out_valid_q;
	dmr_pkg::level_t    left_cmd;
	dmr_pkg::level_t    right_cmd;
	dmr_pkg::tgt_ctrl_t tgc;
	dmr_pkg::lvl_ctrl_t lvc;
	logic               running_next;
	dmr_pkg::wrk_t      l_tgt_mid;
	dmr_pkg::wrk_t      r_tgt_mid;
	dmr_pkg::wrk_t      l_ramped;
	dmr_pkg::wrk_t      r_ramped;
	dmr_pkg::level_t    l_level_next;
	dmr_pkg::level_t    r_level_next;
	dmr_pkg::level_t    l_emit;
	dmr_pkg::level_t    r_emit;
	dmr_pkg::level_t    l_emit_s1;
	dmr_pkg::level_t    r_emit_s1;
	dmr_pkg::level_t    l_level_s1;
	dmr_pkg::level_t    r_level_s1;
	logic               running_s1;
	dmr_pkg::level_t    l_level_s2;
	dmr_pkg::level_t    r_level_s2;
	logic               running_s2;
	dmr_pkg::speed_t    l_speed;
	dmr_pkg::speed_t    r_speed;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_limit_q  <= dmr_pkg::RST_LEVEL_LIMIT;
			min_straight_q <= dmr_pkg::RST_MIN_STRAIGHT;
			min_turning_q  <= dmr_pkg::RST_MIN_TURNING;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				dmr_pkg::REG_LEVEL_LIMIT:  level_limit_q  <= pwdata[9:0];
				dmr_pkg::REG_MIN_STRAIGHT: min_straight_q <= pwdata[9:0];
				dmr_pkg::REG_MIN_TURNING:  min_turning_q  <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			dmr_pkg::REG_LEVEL_LIMIT:  prdata = {22'd0, level_limit_q};
			dmr_pkg::REG_MIN_STRAIGHT: prdata = {22'd0, min_straight_q};
			dmr_pkg::REG_MIN_TURNING:  prdata = {22'd0, min_turning_q};
			default:                   prdata = '0;
		endcase
	end

	assign left_cmd  = s_tdata[10:0];
	assign right_cmd = s_tdata[21:11];
	assign adv2      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || adv2;
	assign accept    = s_tvalid && s_tready;

	dmr_ctrl u_ctrl (
		.clk                (clk),
		.arst_n             (arst_n),
		.accept             (accept),
		.stop_released      (s_tuser),
		.left_command       (left_cmd),
		.right_command      (right_cmd),
		.level_limit        (level_limit_q),
		.min_level_straight (min_straight_q),
		.min_level_turning  (min_turning_q),
		.left_target_mid    (l_tgt_mid),
		.right_target_mid   (r_tgt_mid),
		.left_ramped        (l_ramped),
		.left_level_next    (l_level_next),
		.tgc                (tgc),
		.lvc                (lvc),
		.running_next       (running_next)
	);

	dmr_lane u_lane_left (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.command    (left_cmd),
		.tgc        (tgc),
		.lvc        (lvc),
		.target_mid (l_tgt_mid),
		.ramped     (l_ramped),
		.level_next (l_level_next),
		.emit       (l_emit)
	);

	dmr_lane u_lane_right (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.command    (right_cmd),
		.tgc        (tgc),
		.lvc        (lvc),
		.target_mid (r_tgt_mid),
		.ramped     (r_ramped),
		.level_next (r_level_next),
		.emit       (r_emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv2) begin
				valid_s1 <= 1'b0;
			end
			if (adv2) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			l_emit_s1  <= l_emit;
			r_emit_s1  <= r_emit;
			l_level_s1 <= l_level_next;
			r_level_s1 <= r_level_next;
			running_s1 <= running_next;
		end
		if (adv2) begin
			l_level_s2 <= l_level_s1;
			r_level_s2 <= r_level_s1;
			running_s2 <= running_s1;
		end
	end

	dmr_speed u_speed_left (
		.clk   (clk),
		.en    (adv2),
		.level (l_emit_s1),
		.speed (l_speed)
	);

	dmr_speed u_speed_right (
		.clk   (clk),
		.en    (adv2),
		.level (r_emit_s1),
		.speed (r_speed)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, r_level_s2, l_level_s2, r_speed, l_speed};
	assign m_tuser  = running_s2;

endmodule

// ===== hw/rtl/dmr_checker.sv =====
// Port-level checks for the dual motor ramp unit, attached to the top level by bind.
// Depends only on the top level's ports.
module dmr_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        pready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Output transaction changed while stalled.");

	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:0] != 8'h80 && m_tdata[15:8] != 8'h80)
		else $error("Motor speed outside the range -127 to 127.");

	a_speed_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[7] || m_tdata[26]) && (!m_tdata[15] || m_tdata[37]))
		else $error("Negative speed reported with a non-negative level.");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("Configuration port inserted a wait state.");

endmodule

bind dual_motor_ramp_with_deadband_unit dmr_port_checks u_dmr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.pready   (pready)
);
